/* rtl/core/ttoi_pkg.sv */
package ttoi_pkg;

	localparam int unsigned CH_W    = 8;
	localparam int unsigned RADIX_W = 6;
	localparam int unsigned VAL_W   = 64;
	localparam int unsigned ST_W    = 3;
	localparam int unsigned PH_W    = 2;
	localparam int unsigned SYM_W   = 6;
	// product of magnitude and radix plus one digit
	localparam int unsigned ACC_W   = VAL_W + RADIX_W;

	localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

	localparam logic [ST_W-1:0] ST_OK         = 3'd0;
	localparam logic [ST_W-1:0] ST_BAD_BASE   = 3'd1;
	localparam logic [ST_W-1:0] ST_BAD_SYMBOL = 3'd2;
	localparam logic [ST_W-1:0] ST_OVERFLOW   = 3'd3;
	localparam logic [ST_W-1:0] ST_UNDERFLOW  = 3'd4;

	localparam logic [PH_W-1:0] PH_SPACE = 2'd0;
	localparam logic [PH_W-1:0] PH_SIGN  = 2'd1;
	localparam logic [PH_W-1:0] PH_DIGIT = 2'd2;
	localparam logic [PH_W-1:0] PH_STOP  = 2'd3;

	localparam logic [CH_W-1:0] CH_NUL   = 8'd0;
	localparam logic [CH_W-1:0] CH_TAB   = 8'd9;
	localparam logic [CH_W-1:0] CH_CR    = 8'd13;
	localparam logic [CH_W-1:0] CH_SPACE = 8'd32;
	localparam logic [CH_W-1:0] CH_PLUS  = 8'd43;
	localparam logic [CH_W-1:0] CH_MINUS = 8'd45;
	localparam logic [CH_W-1:0] CH_ZERO  = 8'd48;
	localparam logic [CH_W-1:0] CH_NINE  = 8'd57;
	localparam logic [CH_W-1:0] CH_UC_A  = 8'd65;
	localparam logic [CH_W-1:0] CH_UC_Z  = 8'd90;
	localparam logic [CH_W-1:0] CH_LC_A  = 8'd97;
	localparam logic [CH_W-1:0] CH_LC_Z  = 8'd122;
	localparam logic [CH_W-1:0] UC_OFS   = 8'd55;
	localparam logic [CH_W-1:0] LC_OFS   = 8'd87;

	localparam logic [VAL_W-1:0] MAG_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic [VAL_W-1:0] MAG_MIN = {1'b1, {(VAL_W-1){1'b0}}};

	typedef struct packed {
		logic             term;
		logic             space;
		logic             plus;
		logic             minus;
		logic             sym;
		logic [SYM_W-1:0] sym_val;
	} ch_class_t;

endpackage

/* rtl/core/ttoi_classify.sv */
module ttoi_classify
	import ttoi_pkg::*;
(
	input  logic [CH_W-1:0] ch,
	output ch_class_t       cls
);

	logic [CH_W-1:0] diff;

	always_comb begin
		cls = '0;
		diff = '0;
		cls.term  = (ch == CH_NUL);
		cls.plus  = (ch == CH_PLUS);
		cls.minus = (ch == CH_MINUS);
		case (ch) inside
			[CH_TAB:CH_CR], CH_SPACE: begin
				cls.space = 1'b1;
			end
			[CH_ZERO:CH_NINE]: begin
				cls.sym = 1'b1;
				diff = ch - CH_ZERO;
			end
			[CH_UC_A:CH_UC_Z]: begin
				cls.sym = 1'b1;
				diff = ch - UC_OFS;
			end
			[CH_LC_A:CH_LC_Z]: begin
				cls.sym = 1'b1;
				diff = ch - LC_OFS;
			end
			default: begin
				cls.sym = 1'b0;
			end
		endcase
		cls.sym_val = diff[SYM_W-1:0];
	end

endmodule

/* rtl/core/ttoi_accum.sv */
module ttoi_accum
	import ttoi_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [RADIX_W-1:0] cfg_wr_data,
	input  logic               step,
	input  ch_class_t          cls,
	output logic [VAL_W-1:0]   res_value,
	output logic [ST_W-1:0]    res_status
);

	logic [RADIX_W-1:0] radix_q;
	logic [PH_W-1:0]    phase_q, phase_d;
	logic               neg_q, neg_d;
	logic [VAL_W-1:0]   mag_q, mag_d;
	logic [ST_W-1:0]    err_q, err_d;
	logic [ACC_W-1:0]   acc;
	logic               sign_ok;

	// magnitude stays at most MAG_MAX, so anything above bit VAL_W-2 is overflow
	assign acc = mag_q * radix_q + ACC_W'(cls.sym_val);

	always_comb begin
		phase_d = phase_q;
		neg_d   = neg_q;
		mag_d   = mag_q;
		err_d   = err_q;
		sign_ok = (phase_q == PH_SIGN) || (phase_q == PH_SPACE && !cls.space);
		if (cls.term) begin
			phase_d = PH_SPACE;
			neg_d   = 1'b0;
			mag_d   = '0;
			err_d   = ST_OK;
		end else if (phase_q != PH_STOP && !(phase_q == PH_SPACE && cls.space)) begin
			if (sign_ok && (cls.plus || cls.minus)) begin
				neg_d   = neg_q ^ cls.minus;
				phase_d = PH_SIGN;
			end else if (!cls.sym) begin
				err_d   = ST_BAD_SYMBOL;
				phase_d = PH_STOP;
			end else if (cls.sym_val >= radix_q) begin
				err_d   = ST_BAD_BASE;
				phase_d = PH_STOP;
			end else if (acc[ACC_W-1:VAL_W-1] != '0) begin
				err_d   = neg_q ? ST_UNDERFLOW : ST_OVERFLOW;
				phase_d = PH_STOP;
			end else begin
				mag_d   = acc[VAL_W-1:0];
				phase_d = PH_DIGIT;
			end
		end
	end

	always_comb begin
		case (err_q)
			ST_OK:        res_value = neg_q ? (VAL_W'(0) - mag_q) : mag_q;
			ST_OVERFLOW:  res_value = MAG_MAX;
			ST_UNDERFLOW: res_value = MAG_MIN;
			default:      res_value = '0;
		endcase
	end
	assign res_status = err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (cfg_wr_en) begin
			radix_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SPACE;
			neg_q   <= 1'b0;
			mag_q   <= '0;
			err_q   <= ST_OK;
		end else if (step) begin
			phase_q <= phase_d;
			neg_q   <= neg_d;
			mag_q   <= mag_d;
			err_q   <= err_d;
		end
	end

endmodule

/* rtl/core/text_to_integer_parser.sv */
// Character stream to signed 64-bit integer parser, strtol style, in the base
// held in the radix register (reset 10). One character is taken per cycle with
// no bubbles: the parse state (phase, sign, magnitude, status) updates in a
// single stage whose critical path is one 64x6 multiply-add and overflow
// compare. Each character waits in the input register, and a result is loaded
// into the output register when its zero terminator steps the parse state from
// that register. Only the terminator stalls the input, and only while an
// earlier result still waits on the output. Write radix only while idle.
module text_to_integer_parser
	import ttoi_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_wr_en,
	input  logic [RADIX_W-1:0]      cfg_wr_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [CH_W-1:0]         ch,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [VAL_W-1:0] value,
	output logic [ST_W-1:0]         status
);

	logic             valid_s1;
	logic [CH_W-1:0]  ch_s1;
	ch_class_t        cls;
	logic             advance;
	logic             step;
	logic             load_out;
	logic [VAL_W-1:0] res_value;
	logic [ST_W-1:0]  res_status;
	logic             out_valid_q;
	logic [VAL_W-1:0] value_q;
	logic [ST_W-1:0]  status_q;

	ttoi_classify u_cls (
		.ch  (ch_s1),
		.cls (cls)
	);

	ttoi_accum u_acc (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.step        (step),
		.cls         (cls),
		.res_value   (res_value),
		.res_status  (res_status)
	);

	assign advance  = !cls.term || !out_valid_q || out_ready;
	assign step     = valid_s1 && advance;
	assign load_out = step && cls.term;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			ch_s1 <= ch;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			value_q  <= res_value;
			status_q <= res_status;
		end
	end

	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign status    = status_q;

	a_ovf_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_OVERFLOW |-> value == MAG_MAX)
		else $error("overflow result not saturated to max");

	a_udf_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_UNDERFLOW |-> value == MAG_MIN)
		else $error("underflow result not saturated to min");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_BAD_BASE || status == ST_BAD_SYMBOL) |-> value == '0)
		else $error("symbol error result not zero");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !load_out)
		else $error("result overwritten while held");

endmodule

/* sim/tb_text_to_integer_parser.sv */
`timescale 1ns / 100ps

module tb_text_to_integer_parser;
	import ttoi_pkg::*;

	localparam int unsigned LIMIT       = 400000;
	localparam int unsigned PHASE_CHARS = 60;
	localparam int unsigned N_PHASES    = 11;

	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic [ST_W-1:0]  status;
	} parsed_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_wr_en = 1'b0;
	logic [RADIX_W-1:0]      cfg_wr_data = '0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic [CH_W-1:0]         ch = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic signed [VAL_W-1:0] value;
	logic [ST_W-1:0]         status;

	// parser state as the testbench sees it
	logic [RADIX_W-1:0] num_radix = RADIX_RESET;
	logic [PH_W-1:0]    num_phase = PH_SPACE;
	logic               num_neg = 1'b0;
	logic [VAL_W-1:0]   num_mag = '0;
	logic [ST_W-1:0]    num_err = ST_OK;

	logic [CH_W-1:0] char_q[$];
	parsed_t         pending_numbers[$];

	bit          idle_on = 1'b1;
	int unsigned n_errors = 0;
	int unsigned n_checked = 0;
	int unsigned n_chars = 0;
	int unsigned n_strings = 0;
	int unsigned cycles = 0;

	text_to_integer_parser uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.ch          (ch),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.value       (value),
		.status      (status)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic int symbol_of(input logic [CH_W-1:0] c);
		if (c >= CH_ZERO && c <= CH_NINE)
			return int'(c - CH_ZERO);
		if (c >= CH_LC_A && c <= CH_LC_Z)
			return int'(c - LC_OFS);
		if (c >= CH_UC_A && c <= CH_UC_Z)
			return int'(c - UC_OFS);
		return -1;
	endfunction

	// advance the parse by one accepted character; the terminator yields a number
	task automatic parse_char(input logic [CH_W-1:0] c);
		parsed_t          res;
		int               sym;
		logic [VAL_W-1:0] d;
		logic [VAL_W-1:0] rdx;
		sym = symbol_of(c);
		if (c == CH_NUL) begin
			case (num_err)
				ST_OK:        res.value = num_neg ? -num_mag : num_mag;
				ST_OVERFLOW:  res.value = MAG_MAX;
				ST_UNDERFLOW: res.value = MAG_MIN;
				default:      res.value = '0;
			endcase
			res.status = num_err;
			pending_numbers.push_back(res);
			num_phase = PH_SPACE;
			num_neg = 1'b0;
			num_mag = '0;
			num_err = ST_OK;
		end else if (num_phase == PH_STOP ||
				(num_phase == PH_SPACE &&
				(c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)))) begin
			// skipped
		end else if (num_phase != PH_DIGIT && (c == CH_PLUS || c == CH_MINUS)) begin
			if (c == CH_MINUS)
				num_neg = ~num_neg;
			num_phase = PH_SIGN;
		end else if (sym < 0) begin
			num_err = ST_BAD_SYMBOL;
			num_phase = PH_STOP;
		end else begin
			d = VAL_W'(sym);
			rdx = VAL_W'(num_radix);
			if (d >= rdx) begin
				num_err = ST_BAD_BASE;
				num_phase = PH_STOP;
			end else if (num_mag > (MAG_MAX - d) / rdx) begin
				num_err = num_neg ? ST_UNDERFLOW : ST_OVERFLOW;
				num_phase = PH_STOP;
			end else begin
				num_mag = num_mag * rdx + d;
				num_phase = PH_DIGIT;
			end
		end
	endtask

	function automatic logic [CH_W-1:0] digit_char(input int v);
		if (v < 10)
			return CH_ZERO + CH_W'(v);
		return ($urandom_range(0, 1) ? CH_LC_A : CH_UC_A) + CH_W'(v - 10);
	endfunction

	// one string plus terminator; returns the number of characters queued
	function automatic int unsigned gen_string(input int unsigned r);
		logic [CH_W-1:0]  s[$];
		logic [CH_W-1:0]  digs[$];
		logic [VAL_W-1:0] b;
		int unsigned      kind;
		int unsigned      nd;
		int               top;
		kind = $urandom_range(0, 99);
		top = (r == 0) ? 35 : ((r > 36) ? 35 : int'(r) - 1);
		repeat ($urandom_range(0, 2))
			s.push_back($urandom_range(0, 5) == 5 ? CH_SPACE : CH_TAB + CH_W'($urandom_range(0, 4)));
		repeat ($urandom_range(0, 2))
			s.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
		if (kind < 12 && r >= 2 && r <= 36) begin
			// right around the 2^63-1 edge
			b = MAG_MAX - 64'd1 + VAL_W'($urandom_range(0, 2));
			while (b != 0) begin
				digs.push_front(digit_char(int'(b % VAL_W'(r))));
				b = b / VAL_W'(r);
			end
			if ($urandom_range(0, 3) == 0)
				digs.push_front(CH_ZERO);
		end else begin
			nd = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 6);
			repeat (nd)
				digs.push_back(digit_char($urandom_range(0, top)));
		end
		s = {s, digs};
		if (kind >= 70 && kind < 85)
			s.insert($urandom_range(0, s.size()), CH_W'($urandom_range(1, 255)));
		if (kind >= 85) begin
			s.delete();
			repeat ($urandom_range(1, 6))
				s.push_back(CH_W'($urandom_range(1, 255)));
		end
		s.push_back(CH_NUL);
		char_q = {char_q, s};
		n_strings++;
		return s.size();
	endfunction

	task automatic wait_drained();
		while (char_q.size() != 0 || in_valid || pending_numbers.size() != 0)
			@(negedge clk);
	endtask

	task automatic set_radix(input logic [RADIX_W-1:0] r);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= r;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		num_radix = r;
	endtask

	// input side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			ch <= '0;
		end else begin
			if (in_valid && in_ready) begin
				parse_char(ch);
				n_chars++;
			end
			if (!in_valid || in_ready) begin
				if (char_q.size() != 0 && !(idle_on && $urandom_range(0, 99) < 36)) begin
					in_valid <= 1'b1;
					ch <= char_q.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// output side
	always @(posedge clk or negedge arst_n) begin
		parsed_t e;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (pending_numbers.size() == 0) begin
					$error("result with none expected: value %0d status %0d", value, status);
					n_errors++;
				end else begin
					e = pending_numbers.pop_front();
					n_checked++;
					if (value !== e.value) begin
						$error("value: expected %0d, got %0d", $signed(e.value), value);
						n_errors++;
					end
					if (status !== e.status) begin
						$error("status: expected %0d, got %0d", e.status, status);
						n_errors++;
					end
				end
			end
			out_ready <= !(idle_on && $urandom_range(0, 99) < 36);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("tb_text_to_integer_parser NOT OK");
			$finish;
		end
	end

	initial begin
		logic [RADIX_W-1:0] radix_plan[N_PHASES];
		int unsigned        queued;
		radix_plan = '{RADIX_RESET, 6'd2, 6'd16, 6'd32, 6'd0, 6'd1, 6'd63, 6'd36, 6'd8,
			RADIX_W'($urandom_range(2, 32)), RADIX_W'($urandom_range(2, 32))};
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed strings under the reset radix of 10
		char_q = '{
			CH_SPACE, CH_TAB, CH_CR, CH_MINUS, CH_PLUS, "4", "2", CH_NUL, // -42
			CH_NUL,                                                        // empty
			"a", CH_NUL,                                                   // digit above base
			"9", CH_SPACE, CH_NUL,                                         // space after digit
			"5", CH_MINUS, CH_NUL,                                         // sign after digit
			8'hFF, CH_NUL,                                                 // not a symbol
			CH_MINUS, CH_MINUS, CH_NUL,                                    // signs only
			CH_PLUS, 8'd11, CH_NUL                                         // space after sign
		};
		n_strings = 8;
		queued = char_q.size();

		for (int p = 0; p < N_PHASES; p++) begin
			if (p != 0) begin
				wait_drained();
				repeat (4) @(posedge clk);
				set_radix(radix_plan[p]);
				queued = 0;
			end
			// one stretch without any idling on either side
			idle_on = (p != 2);
			while (queued < PHASE_CHARS)
				queued += gen_string(radix_plan[p]);
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (pending_numbers.size() != 0) begin
			$error("%0d expected numbers never came out", pending_numbers.size());
			n_errors++;
		end
		$display("parsed %0d strings (%0d characters) under %0d radix settings",
			n_strings, n_chars, N_PHASES);
		$display("%0d numbers checked, %0d mismatches", n_checked, n_errors);
		if (n_errors == 0)
			$display("tb_text_to_integer_parser OK");
		else
			$display("tb_text_to_integer_parser NOT OK");
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/ttoi_pkg.sv
rtl/core/ttoi_classify.sv
rtl/core/ttoi_accum.sv
rtl/core/text_to_integer_parser.sv
sim/tb_text_to_integer_parser.sv
